### rtl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types and constants for the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int IO_WIDTH = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_GO,
    ST_RED_WAIT,
    ST_CHECK,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_SQR_GO,
    ST_SQR_WAIT,
    ST_FINISH
  } mexp_state_t;

  typedef enum logic [1:0] {
    SEL_RED,
    SEL_MUL,
    SEL_SQR
  } mexp_sel_t;

  typedef struct packed {
    logic      take;
    logic      mul_start;
    mexp_sel_t sel;
    logic      acc_wr;
    logic      b_wr;
    logic      e_shift;
    logic      out_load;
  } mexp_cmd_t;

  typedef struct packed {
    logic req_valid;
    logic m_zero;
    logic e_zero;
    logic e_lsb;
    logic mul_done;
    logic out_free;
  } mexp_status_t;

endpackage

### rtl/mexp_ifs.sv
// ----------------------------------------------------------------------------
// mexp_ifs
// Request, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mexp_req_if;
  logic                          valid;
  logic                          ready;
  logic [mexp_pkg::IO_WIDTH-1:0] base_value;
  logic [mexp_pkg::IO_WIDTH-1:0] exponent;
  modport source(output valid, base_value, exponent, input ready);
  modport sink(input valid, base_value, exponent, output ready);
endinterface

interface mexp_res_if;
  logic                          valid;
  logic                          ready;
  logic [mexp_pkg::IO_WIDTH-1:0] power_result;
  logic                          bad_modulus;
  modport source(output valid, power_result, bad_modulus, input ready);
  modport sink(input valid, power_result, bad_modulus, output ready);
endinterface

interface mexp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mexp_pkg::IO_WIDTH-1:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

### rtl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation
// base^exponent mod modulus by right-to-left square-and-multiply.
// ----------------------------------------------------------------------------
// One request at a time. All modular products run through one bit-serial
// interleaved multiplier. A request does one base reduction, one squaring
// per exponent bit up to the highest set bit and one multiply per set bit;
// a zero modulus skips the multiplier. A new request is taken while the
// previous result still waits in the output register. Write the modulus
// only while no request is in progress.
module modular_exponentiation #(
  parameter int DATA_WIDTH = 32,
  parameter int EXP_WIDTH  = 32
) (
  input logic        clk,
  input logic        rst,
  mexp_req_if.sink   req,
  mexp_res_if.source res,
  mexp_cfg_if.sink   cfg
);
  import mexp_pkg::*;

  mexp_cmd_t    cmd;
  mexp_status_t status;

  mexp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  mexp_datapath #(
    .DATA_WIDTH (DATA_WIDTH),
    .EXP_WIDTH  (EXP_WIDTH)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .res    (res),
    .cfg    (cfg),
    .cmd    (cmd),
    .status (status)
  );

endmodule

### rtl/mexp_datapath.sv
// ----------------------------------------------------------------------------
// mexp_datapath
// Operand registers, bit-serial interleaved modular multiplier, output stage.
// ----------------------------------------------------------------------------
module mexp_datapath #(
  parameter int DATA_WIDTH = 32,
  parameter int EXP_WIDTH  = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  mexp_req_if.sink               req,
  mexp_res_if.source             res,
  mexp_cfg_if.sink               cfg,
  input  mexp_pkg::mexp_cmd_t    cmd,
  output mexp_pkg::mexp_status_t status
);
  import mexp_pkg::*;

  localparam int CNT_W = $clog2(DATA_WIDTH);

  logic [DATA_WIDTH-1:0] modulus;
  logic [DATA_WIDTH-1:0] base_reg;
  logic [DATA_WIDTH-1:0] acc;
  logic [DATA_WIDTH-1:0] b_run;
  logic [EXP_WIDTH-1:0]  e_reg;

  logic [DATA_WIDTH-1:0] prod;
  logic [DATA_WIDTH-1:0] x_sr;
  logic [DATA_WIDTH-1:0] y_op;
  logic [CNT_W-1:0]      cnt;
  logic                  busy;
  logic                  done;

  logic [IO_WIDTH-1:0]   power_result;
  logic                  bad_modulus;
  logic                  res_valid;

  logic [DATA_WIDTH-1:0] x_start;
  logic [DATA_WIDTH-1:0] y_start;
  logic [DATA_WIDTH:0]   dbl;
  logic [DATA_WIDTH-1:0] t1;
  logic [DATA_WIDTH:0]   sum;
  logic [DATA_WIDTH-1:0] prod_next;
  logic                  m_zero;
  logic                  accept;

  assign m_zero = (modulus == '0);
  assign accept = req.valid && cmd.take;

  always_comb begin
    case (cmd.sel)
      SEL_RED: begin
        x_start = base_reg;
        y_start = DATA_WIDTH'(1);
      end
      SEL_MUL: begin
        x_start = acc;
        y_start = b_run;
      end
      SEL_SQR: begin
        x_start = b_run;
        y_start = b_run;
      end
      default: begin
        x_start = b_run;
        y_start = b_run;
      end
    endcase
  end

  // r = 2r + bit*y, each half reduced by one conditional subtract (y <= m)
  always_comb begin
    dbl = {prod, 1'b0};
    if (dbl >= {1'b0, modulus}) begin
      t1 = DATA_WIDTH'(dbl - {1'b0, modulus});
    end else begin
      t1 = DATA_WIDTH'(dbl);
    end
    sum = {1'b0, t1} + (x_sr[DATA_WIDTH-1] ? {1'b0, y_op} : '0);
    if (sum >= {1'b0, modulus}) begin
      prod_next = DATA_WIDTH'(sum - {1'b0, modulus});
    end else begin
      prod_next = DATA_WIDTH'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus   <= DATA_WIDTH'(2);
      busy      <= 1'b0;
      done      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        modulus <= DATA_WIDTH'(cfg.data);
      end
      done <= 1'b0;
      if (cmd.mul_start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
      if (cmd.out_load) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      base_reg <= DATA_WIDTH'(req.base_value);
      e_reg    <= EXP_WIDTH'(req.exponent);
      acc      <= DATA_WIDTH'(1);
    end else begin
      if (cmd.acc_wr) begin
        acc <= prod;
      end
      if (cmd.b_wr) begin
        b_run <= prod;
      end
      if (cmd.e_shift) begin
        e_reg <= e_reg >> 1;
      end
    end
    if (cmd.mul_start) begin
      prod <= '0;
      x_sr <= x_start;
      y_op <= y_start;
      cnt  <= CNT_W'(DATA_WIDTH - 1);
    end else if (busy) begin
      prod <= prod_next;
      x_sr <= x_sr << 1;
      cnt  <= cnt - 1'b1;
    end
    if (cmd.out_load) begin
      power_result <= m_zero ? '0 : IO_WIDTH'(acc);
      bad_modulus  <= m_zero;
    end
  end

  assign req.ready        = cmd.take;
  assign cfg.ready        = 1'b1;
  assign res.valid        = res_valid;
  assign res.power_result = power_result;
  assign res.bad_modulus  = bad_modulus;

  assign status.req_valid = req.valid;
  assign status.m_zero    = m_zero;
  assign status.e_zero    = (e_reg == '0);
  assign status.e_lsb     = e_reg[0];
  assign status.mul_done  = done;
  assign status.out_free  = !res_valid || res.ready;

endmodule

### rtl/mexp_ctrl.sv
// ----------------------------------------------------------------------------
// mexp_ctrl
// Sequencer for base reduction and the square-and-multiply bit loop.
// ----------------------------------------------------------------------------
module mexp_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  mexp_pkg::mexp_status_t status,
  output mexp_pkg::mexp_cmd_t    cmd
);
  import mexp_pkg::*;

  mexp_state_t state;
  mexp_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (status.req_valid) begin
          state_next = status.m_zero ? ST_FINISH : ST_RED_GO;
        end
      end
      ST_RED_GO:   state_next = ST_RED_WAIT;
      ST_RED_WAIT: begin
        if (status.mul_done) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.e_zero) begin
          state_next = ST_FINISH;
        end else if (status.e_lsb) begin
          state_next = ST_MUL_GO;
        end else begin
          state_next = ST_SQR_GO;
        end
      end
      ST_MUL_GO:   state_next = ST_MUL_WAIT;
      ST_MUL_WAIT: begin
        if (status.mul_done) begin
          state_next = ST_SQR_GO;
        end
      end
      ST_SQR_GO:   state_next = ST_SQR_WAIT;
      ST_SQR_WAIT: begin
        if (status.mul_done) begin
          state_next = ST_CHECK;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.sel = SEL_RED;
    case (state)
      ST_IDLE:     cmd.take = 1'b1;
      ST_RED_GO:   cmd.mul_start = 1'b1;
      ST_RED_WAIT: cmd.b_wr = status.mul_done;
      ST_MUL_GO: begin
        cmd.sel       = SEL_MUL;
        cmd.mul_start = 1'b1;
      end
      ST_MUL_WAIT: cmd.acc_wr = status.mul_done;
      ST_SQR_GO: begin
        cmd.sel       = SEL_SQR;
        cmd.mul_start = 1'b1;
      end
      ST_SQR_WAIT: begin
        cmd.b_wr    = status.mul_done;
        cmd.e_shift = status.mul_done;
      end
      ST_FINISH:   cmd.out_load = status.out_free;
      default:     cmd.take = 1'b0;
    endcase
  end

endmodule

### rtl/mexp_checker.sv
// ----------------------------------------------------------------------------
// mexp_checker
// Port-level checks on the result channel of modular_exponentiation.
// ----------------------------------------------------------------------------
module mexp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic [mexp_pkg::IO_WIDTH-1:0] power_result,
  input logic                          bad_modulus
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(power_result) && $stable(bad_modulus))
    else $error("result changed while stalled");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && bad_modulus |-> power_result == '0)
    else $error("bad modulus with nonzero result");

  a_rst_clear: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .power_result (res.power_result),
  .bad_modulus  (res.bad_modulus)
);

### tb/modular_exponentiation_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modular_exponentiation_tb
// Self-checking bench for the square-and-multiply modular exponentiation.
// A directed table covers the register extremes, a zero modulus, a modulus
// of one and the zero exponent. Random phases follow, each under a new
// modulus. Every result is checked in arrival order against a typed value
// or a local model, with random idle cycles on request and result channels.
// ----------------------------------------------------------------------------
module modular_exponentiation_tb;
  import mexp_pkg::*;

  localparam int W          = IO_WIDTH;
  localparam int IDLE_LIMIT = 20000;
  localparam int PHASES     = 8;
  localparam int PHASE_REQS = 33;

  typedef struct {
    logic [W-1:0] power;
    logic         bad;
  } power_t;

  typedef enum logic {ROW_CFG, ROW_REQ} row_kind_t;

  typedef struct {
    row_kind_t    kind;
    logic [W-1:0] base_value;
    logic [W-1:0] exponent;
    logic         typed;
    logic [W-1:0] power;
    logic         bad;
  } row_t;

  logic clk;
  logic rst;
  logic quiet;

  mexp_req_if req_ch ();
  mexp_res_if res_ch ();
  mexp_cfg_if cfg_ch ();

  power_t       pending_powers[$];
  row_t         dir_tbl[$];
  logic [W-1:0] modulus_q;
  int           fail_cnt = 0;
  int           res_cnt = 0;
  int           idle_cycles = 0;

  modular_exponentiation u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch),
    .cfg(cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic power_t predict_power(logic [W-1:0] b, logic [W-1:0] e,
                                           logic [W-1:0] m);
    logic [2*W-1:0] acc;
    logic [2*W-1:0] run;
    logic [2*W-1:0] mm;
    logic [W-1:0]   bits;
    power_t         r;
    if (m == '0) begin
      r.power = '0;
      r.bad   = 1'b1;
      return r;
    end
    mm   = {{W{1'b0}}, m};
    run  = {{W{1'b0}}, b} % mm;
    acc  = (2*W)'(1);
    bits = e;
    while (bits != '0) begin
      if (bits[0]) begin
        acc = (acc * run) % mm;
      end
      run  = (run * run) % mm;
      bits = bits >> 1;
    end
    r.power = acc[W-1:0];
    r.bad   = 1'b0;
    return r;
  endfunction

  function automatic void add_row(row_t r);
    dir_tbl.insert(dir_tbl.size(), r);
  endfunction

  // result ready: random stalls except in quiet stretches
  always @(posedge clk) begin
    res_ch.ready <= quiet || ($urandom_range(99) >= 38);
  end

  always @(posedge clk) begin
    power_t want;
    if (res_ch.valid && res_ch.ready) begin
      res_cnt <= res_cnt + 1;
      if (pending_powers.size() == 0) begin
        fail_cnt <= fail_cnt + 1;
        if (fail_cnt < 10) begin
          $display("result %0d: unexpected, got %h bad=%b", res_cnt,
                   res_ch.power_result, res_ch.bad_modulus);
        end
      end else begin
        want = pending_powers.pop_front();
        if (res_ch.power_result !== want.power || res_ch.bad_modulus !== want.bad) begin
          fail_cnt <= fail_cnt + 1;
          if (fail_cnt < 10) begin
            $display("result %0d: expected %h bad=%b, got %h bad=%b", res_cnt,
                     want.power, want.bad, res_ch.power_result, res_ch.bad_modulus);
          end
        end
      end
    end
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // leaves valid high after the request; the caller lowers it
  task automatic send_request(input logic [W-1:0] b, input logic [W-1:0] e,
                              input logic typed, input power_t given);
    while (!quiet && $urandom_range(99) < 38) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.base_value <= b;
    req_ch.exponent   <= e;
    do @(posedge clk); while (!req_ch.ready);
    if (typed) begin
      pending_powers.insert(pending_powers.size(), given);
    end else begin
      pending_powers.insert(pending_powers.size(), predict_power(b, e, modulus_q));
    end
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (pending_powers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_modulus(input logic [W-1:0] value);
    drain_results();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    modulus_q = value;
  endtask

  initial begin
    power_t       given;
    logic [W-1:0] b;
    logic [W-1:0] e;
    logic [W-1:0] m;
    rst               <= 1'b1;
    quiet             <= 1'b0;
    req_ch.valid      <= 1'b0;
    req_ch.base_value <= '0;
    req_ch.exponent   <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.data       <= '0;
    modulus_q         = 2;

    add_row(row_t'{ROW_REQ, 32'd3, 32'd1, 1'b1, 32'd1, 1'b0});
    add_row(row_t'{ROW_REQ, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'd1, 1'b0});
    add_row(row_t'{ROW_REQ, 32'd2, 32'd5, 1'b1, 32'd0, 1'b0});
    add_row(row_t'{ROW_REQ, 32'd0, 32'd0, 1'b1, 32'd1, 1'b0});
    add_row(row_t'{ROW_CFG, 32'd0, 32'd0, 1'b0, 32'd0, 1'b0});
    add_row(row_t'{ROW_REQ, 32'd5, 32'd7, 1'b1, 32'd0, 1'b1});
    add_row(row_t'{ROW_REQ, 32'd0, 32'd0, 1'b1, 32'd0, 1'b1});
    add_row(row_t'{ROW_REQ, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'd0, 1'b1});
    add_row(row_t'{ROW_CFG, 32'd1, 32'd0, 1'b0, 32'd0, 1'b0});
    add_row(row_t'{ROW_REQ, 32'd7, 32'd0, 1'b1, 32'd1, 1'b0});
    add_row(row_t'{ROW_REQ, 32'd7, 32'd5, 1'b1, 32'd0, 1'b0});
    add_row(row_t'{ROW_REQ, 32'hFFFFFFFF, 32'd1, 1'b1, 32'd0, 1'b0});
    add_row(row_t'{ROW_CFG, 32'hFFFFFFFF, 32'd0, 1'b0, 32'd0, 1'b0});
    add_row(row_t'{ROW_REQ, 32'd0, 32'd0, 1'b1, 32'd1, 1'b0});
    add_row(row_t'{ROW_REQ, 32'd0, 32'd1, 1'b1, 32'd0, 1'b0});
    add_row(row_t'{ROW_REQ, 32'd1, 32'hFFFFFFFF, 1'b1, 32'd1, 1'b0});
    add_row(row_t'{ROW_REQ, 32'hFFFFFFFF, 32'd1, 1'b1, 32'd0, 1'b0});
    add_row(row_t'{ROW_REQ, 32'hFFFFFFFE, 32'hFFFFFFFF, 1'b0, 32'd0, 1'b0});
    add_row(row_t'{ROW_CFG, 32'hFFFFFFFB, 32'd0, 1'b0, 32'd0, 1'b0});
    add_row(row_t'{ROW_REQ, 32'd2, 32'hFFFFFFFA, 1'b0, 32'd0, 1'b0});
    add_row(row_t'{ROW_REQ, 32'h12345678, 32'h80000000, 1'b0, 32'd0, 1'b0});
    add_row(row_t'{ROW_CFG, 32'd97, 32'd0, 1'b0, 32'd0, 1'b0});
    add_row(row_t'{ROW_REQ, 32'd5, 32'd96, 1'b0, 32'd0, 1'b0});
    add_row(row_t'{ROW_REQ, 32'd200, 32'd3, 1'b0, 32'd0, 1'b0});
    add_row(row_t'{ROW_CFG, 32'h80000000, 32'd0, 1'b0, 32'd0, 1'b0});
    add_row(row_t'{ROW_REQ, 32'd3, 32'h80000000, 1'b0, 32'd0, 1'b0});

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].kind == ROW_CFG) begin
        write_modulus(dir_tbl[i].base_value);
      end else begin
        given.power = dir_tbl[i].power;
        given.bad   = dir_tbl[i].bad;
        send_request(dir_tbl[i].base_value, dir_tbl[i].exponent, dir_tbl[i].typed, given);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: m = 32'hFFFFFFFF;
        1: m = $urandom | 32'h80000000;
        2: m = $urandom_range(255, 2);
        3: m = 32'd1;
        4: m = 32'd0;
        5: m = $urandom | 32'h1;
        6: m = 32'h80000000;
        default: m = $urandom;
      endcase
      write_modulus(m);
      quiet <= (ph == 2);
      for (int i = 0; i < PHASE_REQS; i++) begin
        if (i == 16) begin
          drain_results();
        end
        case ($urandom_range(9))
          0: b = '0;
          1: b = '1;
          2: b = $urandom_range(15);
          3: b = m + $urandom_range(2) - 1;
          default: b = $urandom;
        endcase
        case ($urandom_range(9))
          0: e = '0;
          1: e = $urandom;
          2: e = '1;
          3: e = 32'd1 << $urandom_range(W-1);
          default: e = $urandom & ((32'd1 << $urandom_range(12, 1)) - 1);
        endcase
        send_request(b, e, 1'b0, given);
      end
    end

    drain_results();
    repeat (50) @(posedge clk);
    if (fail_cnt == 0 && pending_powers.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/mexp_pkg.sv
rtl/mexp_ifs.sv
rtl/mexp_datapath.sv
rtl/mexp_ctrl.sv
rtl/modular_exponentiation.sv
rtl/mexp_checker.sv
tb/modular_exponentiation_tb.sv
